// File: rtl/core/snlva_pkg.sv
// ----------------------------------------------------------------------------
// snlva_pkg
// Shared types and command codes for the sparse nonzero local-view assigner.
// ----------------------------------------------------------------------------
package snlva_pkg;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned INDEX_W = 10;

	typedef enum logic [CMD_W-1:0] {
		CMD_MARK_FIRST  = 3'd0,
		CMD_MARK_SECOND = 3'd1,
		CMD_COUNT       = 3'd2,
		CMD_CLASSIFY    = 3'd3,
		CMD_CLEAR       = 3'd4
	} cmd_e;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [INDEX_W-1:0] row;
		logic [INDEX_W-1:0] col;
	} in_t;

	typedef struct packed {
		logic to_column_part;
		logic row_is_split;
		logic col_is_split;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
		logic clear;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_done;
	} sts_t;

endpackage

// File: rtl/core/snlva_ram.sv
// ----------------------------------------------------------------------------
// snlva_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module snlva_ram #(
	parameter int unsigned WIDTH = 18,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/snlva_ctrl.sv
// ----------------------------------------------------------------------------
// snlva_ctrl
// Controller: accepts commands, sequences execute and the clearing sweep.
// ----------------------------------------------------------------------------
module snlva_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [snlva_pkg::CMD_W-1:0]   cmd,
	input  snlva_pkg::sts_t               sts,
	output snlva_pkg::ctl_t               ctl,
	output logic                          busy
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EXEC  = 3'b010,
		ST_CLEAR = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (cmd == snlva_pkg::CMD_CLEAR) ? ST_CLEAR : ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (sts.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// stores are swept to zero right after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign ctl.capture = (state_q == ST_IDLE) && start;
	assign ctl.execute = (state_q == ST_EXEC);
	assign ctl.clear   = (state_q == ST_CLEAR);

endmodule

// File: rtl/core/snlva_dpath.sv
// ----------------------------------------------------------------------------
// snlva_dpath
// Datapath: row and column tables, read-modify-write update, classification.
// ----------------------------------------------------------------------------
module snlva_dpath #(
	parameter int unsigned MAX_ROWS   = 1024,
	parameter int unsigned MAX_COLS   = 1024,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  snlva_pkg::in_t    item,
	input  snlva_pkg::ctl_t   ctl,
	output snlva_pkg::sts_t   sts,
	output logic              done,
	output snlva_pkg::out_t   result
);

	localparam int unsigned RA    = $clog2(MAX_ROWS);
	localparam int unsigned CA    = $clog2(MAX_COLS);
	localparam int unsigned EW    = COUNT_BITS + 2;
	localparam int unsigned DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int unsigned SW    = $clog2(DEPTH);
	localparam logic [SW-1:0] SWEEP_LAST = SW'(DEPTH - 1);

	// entry layout: {first seen, second seen, count}
	logic [RA-1:0]         row_addr_q;
	logic [CA-1:0]         col_addr_q;
	logic                  row_ok_q;
	logic                  col_ok_q;
	logic [snlva_pkg::CMD_W-1:0] cmd_q;
	logic [SW-1:0]         sweep_q;

	logic [EW-1:0]         row_rdata;
	logic [EW-1:0]         col_rdata;
	logic [EW-1:0]         row_upd;
	logic [EW-1:0]         col_upd;
	logic                  row_we;
	logic                  col_we;
	logic [RA-1:0]         row_waddr;
	logic [CA-1:0]         col_waddr;
	logic [EW-1:0]         row_wdata;
	logic [EW-1:0]         col_wdata;
	logic                  is_update;

	logic                  rs;
	logic                  cs;
	logic [COUNT_BITS-1:0] rc;
	logic [COUNT_BITS-1:0] cc;
	logic                  to_col;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q      <= item.cmd;
			row_addr_q <= RA'(item.row);
			col_addr_q <= CA'(item.col);
			row_ok_q   <= (32'(item.row) < MAX_ROWS);
			col_ok_q   <= (32'(item.col) < MAX_COLS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (ctl.clear) begin
			sweep_q <= (sweep_q == SWEEP_LAST) ? '0 : sweep_q + 1'b1;
		end
	end

	assign sts.sweep_done = ctl.clear && (sweep_q == SWEEP_LAST);

	function automatic logic [EW-1:0] update(input logic [EW-1:0] e,
			input logic [snlva_pkg::CMD_W-1:0] c);
		logic [EW-1:0] r;
		r = e;
		case (c)
			snlva_pkg::CMD_MARK_FIRST:  r[EW-1] = 1'b1;
			snlva_pkg::CMD_MARK_SECOND: r[EW-2] = 1'b1;
			snlva_pkg::CMD_COUNT: begin
				if (e[COUNT_BITS-1:0] != '1) begin
					r[COUNT_BITS-1:0] = e[COUNT_BITS-1:0] + 1'b1;
				end
			end
			default: r = e;
		endcase
		return r;
	endfunction

	always_comb begin
		is_update = (cmd_q == snlva_pkg::CMD_MARK_FIRST) ||
			(cmd_q == snlva_pkg::CMD_MARK_SECOND) || (cmd_q == snlva_pkg::CMD_COUNT);
		row_upd   = update(row_rdata, cmd_q);
		col_upd   = update(col_rdata, cmd_q);
		if (ctl.clear) begin
			row_we    = (32'(sweep_q) < MAX_ROWS);
			col_we    = (32'(sweep_q) < MAX_COLS);
			row_waddr = RA'(sweep_q);
			col_waddr = CA'(sweep_q);
			row_wdata = '0;
			col_wdata = '0;
		end else begin
			row_we    = ctl.execute && is_update && row_ok_q;
			col_we    = ctl.execute && is_update && col_ok_q;
			row_waddr = row_addr_q;
			col_waddr = col_addr_q;
			row_wdata = row_upd;
			col_wdata = col_upd;
		end
	end

	// reads are issued from the input at the transfer edge
	snlva_ram #(.WIDTH(EW), .DEPTH(MAX_ROWS)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.raddr (RA'(item.row)),
		.rdata (row_rdata)
	);

	snlva_ram #(.WIDTH(EW), .DEPTH(MAX_COLS)) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_waddr),
		.wdata (col_wdata),
		.raddr (CA'(item.col)),
		.rdata (col_rdata)
	);

	// out of range index reads as unflagged with zero count
	always_comb begin
		rs     = row_ok_q && row_rdata[EW-1] && row_rdata[EW-2];
		cs     = col_ok_q && col_rdata[EW-1] && col_rdata[EW-2];
		rc     = row_ok_q ? row_rdata[COUNT_BITS-1:0] : '0;
		cc     = col_ok_q ? col_rdata[COUNT_BITS-1:0] : '0;
		to_col = (rs != cs) ? rs : !(rc < cc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.execute && (cmd_q == snlva_pkg::CMD_CLASSIFY);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			result.to_column_part <= to_col;
			result.row_is_split   <= rs;
			result.col_is_split   <= cs;
		end
	end

endmodule

// File: rtl/core/sparse_nonzero_local_view_assign.sv
// ----------------------------------------------------------------------------
// sparse_nonzero_local_view_assign
// Assigns sparse-matrix nonzeros to a row part or a column part.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred on a rising edge where start is high and busy is
//   low. item carries cmd, row and col. Mark and count commands update the
//   per-row and per-column tables with a read-modify-write; classify reads
//   both tables and returns one result.
//   Each mark, count or classify command is read from the table RAMs at the
//   transfer edge, then written back or evaluated in the execute state. busy
//   is high in that state, so the next command cannot be taken until the
//   current one is through; the registered RAM read ahead of the write-back sets this.
//   A classify result appears on result with done high for exactly one cycle,
//   the cycle after the evaluate cycle. The receiver cannot stall it.
//   Clear sweeps both tables to zero, one entry per cycle, over max(MAX_ROWS,
//   MAX_COLS) entries with busy high. The same sweep runs right after reset,
//   so busy stays high after arst_n rises until the sweep is done.
// ----------------------------------------------------------------------------
module sparse_nonzero_local_view_assign #(
	parameter int unsigned MAX_ROWS   = 1024,
	parameter int unsigned MAX_COLS   = 1024,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  snlva_pkg::in_t  item,
	output logic            busy,
	output logic            done,
	output snlva_pkg::out_t result
);

	snlva_pkg::ctl_t ctl;
	snlva_pkg::sts_t sts;

	snlva_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (item.cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	snlva_dpath #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule
